// ===== src/radix_digit_converter_macros.svh =====
// Assertion macros shared by the checker of the radix digit converter.
`ifndef RADIX_DIGIT_CONVERTER_MACROS_SVH
`define RADIX_DIGIT_CONVERTER_MACROS_SVH

// Check a consequence in the same cycle as its trigger.
`define RDC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define RDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rdc_pkg.sv =====
// Shared types, constants, helper functions and microcode for the radix digit converter.
package rdc_pkg;

  // Field widths
  localparam int WORD_W  = 54;
  localparam int DIGIT_W = 4;
  localparam int CODE_W  = 2;

  // Default number of decimal input digits examined
  localparam int IN_DIGITS_DEF = 16;

  // Output digit buffer: base 2 of a 54-bit value needs at most 54 digits
  localparam int MAX_DIGITS = 54;
  localparam int IDX_W      = $clog2(MAX_DIGITS + 1);

  // Divide-by-ten unit: quotient bits resolved per cycle
  localparam int DIV_BITS   = 8;
  localparam int DIV_STEPS  = (WORD_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_PAD_W  = DIV_STEPS * DIV_BITS;
  localparam int DIV_CNT_W  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam logic [DIGIT_W-1:0] DEC_BASE = DIGIT_W'(10);

  // Base codes
  localparam logic [CODE_W-1:0] BASE_2  = 2'd0;
  localparam logic [CODE_W-1:0] BASE_4  = 2'd1;
  localparam logic [CODE_W-1:0] BASE_8  = 2'd2;
  localparam logic [CODE_W-1:0] BASE_10 = 2'd3;

  // Divider request and result
  typedef struct packed {
    logic              go;
    logic [CODE_W-1:0] base;
    logic [WORD_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic [WORD_W-1:0]  quot;
    logic [DIGIT_W-1:0] rem;
  } div_res_t;

  // Numeric value of a base code
  function automatic logic [DIGIT_W-1:0] base_val(input logic [CODE_W-1:0] code);
    logic [DIGIT_W-1:0] v;
    case (code)
      BASE_2:  v = DIGIT_W'(2);
      BASE_4:  v = DIGIT_W'(4);
      BASE_8:  v = DIGIT_W'(8);
      default: v = DEC_BASE;
    endcase
    return v;
  endfunction

  // Shift amount of a power-of-two base
  function automatic logic [1:0] pow2_shift(input logic [CODE_W-1:0] code);
    logic [1:0] s;
    case (code)
      BASE_2:  s = 2'd1;
      BASE_4:  s = 2'd2;
      BASE_8:  s = 2'd3;
      default: s = 2'd0;
    endcase
    return s;
  endfunction

  // Multiply a place weight by a base, wrapping at the word width
  function automatic logic [WORD_W-1:0] mul_base(input logic [WORD_W-1:0] p,
                                                 input logic [CODE_W-1:0] code);
    logic [WORD_W-1:0] r;
    case (code)
      BASE_2:  r = p << 1;
      BASE_4:  r = p << 2;
      BASE_8:  r = p << 3;
      default: r = (p << 3) + (p << 1);
    endcase
    return r;
  endfunction

  // Microcode: datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_XACC,
    OP_OSTORE,
    OP_READ,
    OP_PUSH,
    OP_EPUSH
  } uop_e;

  // Microcode: jump conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_IN,
    C_DIV_BUSY,
    C_MORE_X,
    C_BAD,
    C_QUOT_NZ,
    C_OUT_FULL,
    C_MORE_OUT
  } ucond_e;

  localparam int UPC_W = 4;

  // Step addresses
  localparam logic [UPC_W-1:0] U_IDLE   = UPC_W'(0);
  localparam logic [UPC_W-1:0] U_XDIV   = UPC_W'(1);
  localparam logic [UPC_W-1:0] U_XWAIT  = UPC_W'(2);
  localparam logic [UPC_W-1:0] U_XACC   = UPC_W'(3);
  localparam logic [UPC_W-1:0] U_CHECK  = UPC_W'(4);
  localparam logic [UPC_W-1:0] U_ODIV   = UPC_W'(5);
  localparam logic [UPC_W-1:0] U_OWAIT  = UPC_W'(6);
  localparam logic [UPC_W-1:0] U_OSTORE = UPC_W'(7);
  localparam logic [UPC_W-1:0] U_RD     = UPC_W'(8);
  localparam logic [UPC_W-1:0] U_PUSH   = UPC_W'(9);
  localparam logic [UPC_W-1:0] U_EWAIT  = UPC_W'(10);
  localparam logic [UPC_W-1:0] U_EPUSH  = UPC_W'(11);

  // One control word: jump to tgt when cond holds, else go to nxt
  typedef struct packed {
    logic             in_ready;
    logic             div_go;
    logic             div_src_work;
    logic             div_dec;
    uop_e             op;
    ucond_e           cond;
    logic [UPC_W-1:0] tgt;
    logic [UPC_W-1:0] nxt;
  } uword_t;

  // Control store
  function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
    uword_t w;
    w = '0;
    w.op   = OP_NONE;
    w.cond = C_ALWAYS;
    w.tgt  = U_IDLE;
    w.nxt  = U_IDLE;
    case (addr)
      U_IDLE: begin
        w.in_ready = 1'b1;
        w.op   = OP_LOAD;
        w.cond = C_NO_IN;
        w.tgt  = U_IDLE;
        w.nxt  = U_XDIV;
      end
      U_XDIV: begin
        w.div_go  = 1'b1;
        w.div_dec = 1'b1;
        w.tgt     = U_XWAIT;
      end
      U_XWAIT: begin
        w.cond = C_DIV_BUSY;
        w.tgt  = U_XWAIT;
        w.nxt  = U_XACC;
      end
      U_XACC: begin
        w.op   = OP_XACC;
        w.cond = C_MORE_X;
        w.tgt  = U_XDIV;
        w.nxt  = U_CHECK;
      end
      U_CHECK: begin
        w.cond = C_BAD;
        w.tgt  = U_EWAIT;
        w.nxt  = U_ODIV;
      end
      U_ODIV: begin
        w.div_go       = 1'b1;
        w.div_src_work = 1'b1;
        w.tgt          = U_OWAIT;
      end
      U_OWAIT: begin
        w.cond = C_DIV_BUSY;
        w.tgt  = U_OWAIT;
        w.nxt  = U_OSTORE;
      end
      U_OSTORE: begin
        w.op   = OP_OSTORE;
        w.cond = C_QUOT_NZ;
        w.tgt  = U_ODIV;
        w.nxt  = U_RD;
      end
      U_RD: begin
        w.op   = OP_READ;
        w.cond = C_OUT_FULL;
        w.tgt  = U_RD;
        w.nxt  = U_PUSH;
      end
      U_PUSH: begin
        w.op   = OP_PUSH;
        w.cond = C_MORE_OUT;
        w.tgt  = U_RD;
        w.nxt  = U_IDLE;
      end
      U_EWAIT: begin
        w.cond = C_OUT_FULL;
        w.tgt  = U_EWAIT;
        w.nxt  = U_EPUSH;
      end
      U_EPUSH: begin
        w.op  = OP_EPUSH;
        w.tgt = U_IDLE;
      end
      default: begin
        w.tgt = U_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== src/rdc_div.sv =====
// Shared divider: bases 2, 4 and 8 by shift and mask on the request, eight quotient bits per cycle for base ten.
module rdc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rdc_pkg::div_req_t req_i,
  output logic              busy_o,
  output rdc_pkg::div_res_t res_o
);

  logic [rdc_pkg::DIV_PAD_W-1:0] a_q;
  logic [rdc_pkg::DIGIT_W-1:0]   rem_q;
  logic                          busy_q;
  logic [rdc_pkg::DIV_CNT_W-1:0] cnt_q;

  logic [rdc_pkg::DIGIT_W-1:0]   rem_d;
  logic [rdc_pkg::DIV_BITS-1:0]  qbyte;

  // Resolve the next quotient byte by restoring steps against ten
  always_comb begin
    logic [rdc_pkg::DIGIT_W:0] t;
    rem_d = rem_q;
    qbyte = '0;
    for (int j = 0; j < rdc_pkg::DIV_BITS; j++) begin
      t = {rem_d, a_q[rdc_pkg::DIV_PAD_W-1-j]};
      if (t >= {1'b0, rdc_pkg::DEC_BASE}) begin
        rem_d = rdc_pkg::DIGIT_W'(t - {1'b0, rdc_pkg::DEC_BASE});
        qbyte[rdc_pkg::DIV_BITS-1-j] = 1'b1;
      end else begin
        rem_d = t[rdc_pkg::DIGIT_W-1:0];
      end
    end
  end

  // Track the iteration count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.go) begin
      busy_q <= (req_i.base == rdc_pkg::BASE_10);
      cnt_q  <= rdc_pkg::DIV_CNT_W'(rdc_pkg::DIV_STEPS - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - rdc_pkg::DIV_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Load or advance the dividend and remainder
  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      case (req_i.base)
        rdc_pkg::BASE_2, rdc_pkg::BASE_4, rdc_pkg::BASE_8: begin
          a_q   <= rdc_pkg::DIV_PAD_W'(req_i.dividend >> rdc_pkg::pow2_shift(req_i.base));
          rem_q <= req_i.dividend[rdc_pkg::DIGIT_W-1:0]
                   & (rdc_pkg::base_val(req_i.base) - rdc_pkg::DIGIT_W'(1));
        end
        default: begin
          a_q   <= rdc_pkg::DIV_PAD_W'(req_i.dividend);
          rem_q <= '0;
        end
      endcase
    end else if (busy_q) begin
      a_q   <= {a_q[rdc_pkg::DIV_PAD_W-rdc_pkg::DIV_BITS-1:0], qbyte};
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign res_o.quot = a_q[rdc_pkg::WORD_W-1:0];
  assign res_o.rem  = rem_q;

endmodule

// ===== src/radix_digit_converter.sv =====
// Top level of the radix digit converter: microcoded sequencer, datapath and output register.
//
// Usage: a word on the input channel (number_i, target_base_code_i) is taken when
// in_valid_i is high and in_stall_o is low. The decimal digits of number_i are read
// as digits in the base held in the source base register (cfg_we_i, cfg_wdata_i;
// reset value selects base ten). The result is a run of words on the output channel
// (digit_o, last_o, invalid_o), most significant digit first, last_o on the final
// one; a bad source digit gives one word with invalid_o and last_o set.
// One item at a time: in_stall_o stays high from the accepted word until the last
// result has been moved into the output register.
// Per item, the shared divider runs once for each decimal digit examined (D, up to
// IN_DIGITS, fewer once the remaining digits are zero) and once for each of the K output
// digits, plus output stalls; a bad digit ends the item after the D input digits.
// The cost is set by the shared divider, which resolves eight quotient bits per
// cycle for base ten, and by one control step per operation.
// A stalled output word holds; the sequencer waits on it before pushing the next.
// Reset returns the sequencer to idle, empties the output register and sets base ten.
module radix_digit_converter #(
  parameter int IN_DIGITS = rdc_pkg::IN_DIGITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [rdc_pkg::CODE_W-1:0]   cfg_wdata_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [rdc_pkg::WORD_W-1:0]   number_i,
  input  logic [rdc_pkg::CODE_W-1:0]   target_base_code_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rdc_pkg::DIGIT_W-1:0]  digit_o,
  output logic                         last_o,
  output logic                         invalid_o
);

  localparam int K_W = $clog2(IN_DIGITS + 1);
  localparam logic [K_W-1:0] K_LAST = K_W'(IN_DIGITS - 1);

  // Sequencer and control state
  logic [rdc_pkg::UPC_W-1:0] upc_q, upc_d;
  logic [rdc_pkg::CODE_W-1:0] sb_q;
  logic [K_W-1:0]             k_q, k_d;
  logic [rdc_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic                       out_valid_q, out_valid_d;

  // Datapath registers
  logic [rdc_pkg::WORD_W-1:0]  n_q, n_d;
  logic [rdc_pkg::CODE_W-1:0]  tb_q, tb_d;
  logic [rdc_pkg::WORD_W-1:0]  work_q, work_d;
  logic [rdc_pkg::WORD_W-1:0]  place_q, place_d;
  logic                        bad_q, bad_d;
  logic [rdc_pkg::DIGIT_W-1:0] rd_q;
  logic [rdc_pkg::DIGIT_W-1:0] out_digit_q, out_digit_d;
  logic                        out_last_q, out_last_d;
  logic                        out_inv_q, out_inv_d;

  // Digit buffer, least significant digit at entry zero
  logic [rdc_pkg::DIGIT_W-1:0] dig_mem [rdc_pkg::MAX_DIGITS];

  rdc_pkg::uword_t   uw;
  rdc_pkg::div_req_t div_req;
  rdc_pkg::div_res_t div_res;
  logic              div_busy;
  logic              in_acc;
  logic              out_full;
  logic              cond_hit;
  logic [rdc_pkg::WORD_W+rdc_pkg::DIGIT_W-1:0] prod;

  // Fetch the control word
  assign uw = rdc_pkg::ucode(upc_q);

  assign in_stall_o = ~uw.in_ready;
  assign in_acc     = uw.in_ready & in_valid_i;
  assign out_full   = out_valid_q & out_stall_i;

  // Drive the shared divider
  assign div_req.go       = uw.div_go;
  assign div_req.base     = uw.div_dec ? rdc_pkg::BASE_10 : tb_q;
  assign div_req.dividend = uw.div_src_work ? work_q : n_q;

  rdc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .res_o  (div_res)
  );

  // Evaluate the jump condition
  always_comb begin
    case (uw.cond)
      rdc_pkg::C_ALWAYS:   cond_hit = 1'b1;
      rdc_pkg::C_NO_IN:    cond_hit = ~in_valid_i;
      rdc_pkg::C_DIV_BUSY: cond_hit = div_busy;
      rdc_pkg::C_MORE_X:   cond_hit = (k_q != K_LAST) && (div_res.quot != '0);
      rdc_pkg::C_BAD:      cond_hit = bad_q;
      rdc_pkg::C_QUOT_NZ:  cond_hit = (div_res.quot != '0);
      rdc_pkg::C_OUT_FULL: cond_hit = out_full;
      rdc_pkg::C_MORE_OUT: cond_hit = (idx_q != rdc_pkg::IDX_W'(1));
      default:             cond_hit = 1'b1;
    endcase
  end

  assign upc_d = cond_hit ? uw.tgt : uw.nxt;

  // Weight the current source digit
  assign prod = place_q * div_res.rem;

  // Apply the datapath operation of this step
  always_comb begin
    n_d         = n_q;
    tb_d        = tb_q;
    work_d      = work_q;
    place_d     = place_q;
    bad_d       = bad_q;
    k_d         = k_q;
    idx_d       = idx_q;
    out_digit_d = out_digit_q;
    out_last_d  = out_last_q;
    out_inv_d   = out_inv_q;
    out_valid_d = out_valid_q & out_stall_i;
    case (uw.op)
      rdc_pkg::OP_LOAD: begin
        if (in_acc) begin
          n_d     = number_i;
          tb_d    = target_base_code_i;
          work_d  = '0;
          place_d = rdc_pkg::WORD_W'(1);
          bad_d   = 1'b0;
          k_d     = '0;
          idx_d   = '0;
        end
      end
      rdc_pkg::OP_XACC: begin
        n_d     = div_res.quot;
        bad_d   = bad_q | (div_res.rem >= rdc_pkg::base_val(sb_q));
        work_d  = work_q + prod[rdc_pkg::WORD_W-1:0];
        place_d = rdc_pkg::mul_base(place_q, sb_q);
        k_d     = k_q + K_W'(1);
      end
      rdc_pkg::OP_OSTORE: begin
        work_d = div_res.quot;
        idx_d  = idx_q + rdc_pkg::IDX_W'(1);
      end
      rdc_pkg::OP_PUSH: begin
        out_valid_d = 1'b1;
        out_digit_d = rd_q;
        out_last_d  = (idx_q == rdc_pkg::IDX_W'(1));
        out_inv_d   = 1'b0;
        idx_d       = idx_q - rdc_pkg::IDX_W'(1);
      end
      rdc_pkg::OP_EPUSH: begin
        out_valid_d = 1'b1;
        out_digit_d = '0;
        out_last_d  = 1'b1;
        out_inv_d   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Hold sequencer, counters, output valid and the source base register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= rdc_pkg::U_IDLE;
      k_q         <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      sb_q        <= rdc_pkg::BASE_10;
    end else begin
      upc_q       <= upc_d;
      k_q         <= k_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        sb_q <= cfg_wdata_i;
      end
    end
  end

  // Hold datapath payload
  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    tb_q        <= tb_d;
    work_q      <= work_d;
    place_q     <= place_d;
    bad_q       <= bad_d;
    out_digit_q <= out_digit_d;
    out_last_q  <= out_last_d;
    out_inv_q   <= out_inv_d;
  end

  // Write and read the digit buffer
  always_ff @(posedge clk_i) begin
    if (uw.op == rdc_pkg::OP_OSTORE) begin
      dig_mem[idx_q] <= div_res.rem;
    end
    if (uw.op == rdc_pkg::OP_READ) begin
      rd_q <= dig_mem[idx_q - rdc_pkg::IDX_W'(1)];
    end
  end

  assign out_valid_o = out_valid_q;
  assign digit_o     = out_digit_q;
  assign last_o      = out_last_q;
  assign invalid_o   = out_inv_q;

endmodule

// ===== src/rdc_chk.sv =====
// Port-level checker for the radix digit converter and its bind.
`include "radix_digit_converter_macros.svh"

module rdc_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [rdc_pkg::DIGIT_W-1:0] digit_o,
  input logic                        last_o,
  input logic                        invalid_o
);

  // Hold a stalled output word
  `RDC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(digit_o) && $stable(last_o) && $stable(invalid_o), "stalled output word changed")

  // Close an error result at once with a zero digit
  `RDC_ASSERT_SAME(a_err_last, out_valid_o && invalid_o, last_o && (digit_o == 4'd0), "error word not last or digit not zero")

  // Keep every digit below ten
  `RDC_ASSERT_SAME(a_digit_rng, out_valid_o, digit_o < 4'd10, "output digit out of range")

  // Stall the input right after taking a word
  `RDC_ASSERT_NEXT(a_busy_stall, in_valid_i && !in_stall_o, in_stall_o, "input not stalled after accept")

endmodule

bind radix_digit_converter rdc_chk u_rdc_chk (.*);
